[src/bdr_pkg.sv]
`default_nettype none

package bdr_pkg;

    localparam int DEPTH   = 16;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int FUNC_W  = 3;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_BACK   = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_REVERSE    = 3'd4,
        FN_READ       = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] value;
        logic [INDEX_W-1:0]       index;
    } t_op;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] data;
        logic [COUNT_W-1:0]       count;
    } t_res;

endpackage

`default_nettype wire

[src/bdr_if.sv]
`default_nettype none

interface bdr_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [bdr_pkg::FUNC_W-1:0]               func;
    logic signed [bdr_pkg::WORD_W-1:0]        value;
    logic [bdr_pkg::INDEX_W-1:0]              index;

    modport source (output valid, output func, output value, output index, input ready);
    modport sink   (input valid, input func, input value, input index, output ready);
endinterface

interface bdr_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic [bdr_pkg::STAT_W-1:0]               status;
    logic signed [bdr_pkg::WORD_W-1:0]        data;
    logic [bdr_pkg::COUNT_W-1:0]              count;

    modport source (output valid, output status, output data, output count, input ready);
    modport sink   (input valid, input status, input data, input count, output ready);
endinterface

`default_nettype wire

[src/bdr_core.sv]
`default_nettype none

module bdr_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire bdr_pkg::t_op  i_op,
    output bdr_pkg::t_res      o_res
);
    import bdr_pkg::*;

    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W + 1 : INDEX_W + 1;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_count;
    logic              r_rev;

    logic [PTR_W-1:0]  n_head;
    logic [CNT_W-1:0]  n_count;
    logic              n_rev;

    logic              wr_en;
    logic [PTR_W-1:0]  wr_slot;
    logic [PTR_W-1:0]  rd_pos;
    logic [PTR_W-1:0]  rd_slot;
    logic              use_rd;
    logic [STAT_W-1:0] status;
    logic [PTR_W-1:0]  head_dec;
    logic [PTR_W-1:0]  head_inc;
    logic              full;
    logic              empty;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  cnt_ext;

    // head plus an offset below DEPTH, wrapped with one compare and subtract
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [PTR_W-1:0] pos);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (PTR_W+1)'(DEPTH)) begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign head_dec = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign idx_ext  = CMP_W'(i_op.index);
    assign cnt_ext  = CMP_W'(r_count);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_rev   = r_rev;
        wr_en   = 1'b0;
        wr_slot = slot_of(r_head, PTR_W'(r_count));
        rd_pos  = '0;
        use_rd  = 1'b0;
        status  = ST_OK;
        case (i_op.func)
            FN_PUSH_BACK, FN_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    // reversed order swaps the physical ends
                    if ((i_op.func == FN_PUSH_FRONT) != r_rev) begin
                        n_head  = head_dec;
                        wr_slot = head_dec;
                    end
                end
            end
            FN_POP_BACK, FN_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    use_rd  = 1'b1;
                    n_count = r_count - 1'b1;
                    if ((i_op.func == FN_POP_BACK) != r_rev) begin
                        rd_pos = PTR_W'(r_count - 1'b1);
                    end else begin
                        n_head = head_inc;
                    end
                end
            end
            FN_REVERSE: begin
                n_rev = ~r_rev;
            end
            FN_READ: begin
                if (idx_ext >= cnt_ext) begin
                    status = ST_RANGE;
                end else begin
                    use_rd = 1'b1;
                    if (r_rev) begin
                        rd_pos = PTR_W'(cnt_ext - 1'b1 - idx_ext);
                    end else begin
                        rd_pos = PTR_W'(idx_ext);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign rd_slot = slot_of(r_head, rd_pos);

    always_comb begin
        o_res.status = status;
        o_res.data   = use_rd ? r_mem[rd_slot] : '0;
        o_res.count  = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_fire) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && wr_en) begin
            r_mem[wr_slot] <= i_op.value;
        end
    end

endmodule

`default_nettype wire

[src/bounded_deque_with_reverse_unit.sv]
// a request is held in the input register, then its response in the output register, before it can be taken
// throughput: one request per cycle while responses are taken; pointer and count update in a single pass
// a stalled response holds in the output register while one more request waits
// reset clears head pointer, count, reverse flag and both valid flags
// storage is not cleared; only held entries are ever read
`default_nettype none

module bounded_deque_with_reverse_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bdr_req_if.sink   i_req,
    bdr_rsp_if.source o_rsp
);
    import bdr_pkg::*;

    logic r_in_valid;
    t_op  r_op;
    logic r_out_valid;
    t_res r_res;
    t_res core_res;
    logic advance;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    bdr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_op    (r_op),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op.func  <= i_req.func;
            r_op.value <= i_req.value;
            r_op.index <= i_req.index;
        end
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_res.status;
    assign o_rsp.data   = r_res.data;
    assign o_rsp.count  = r_res.count;

endmodule

`default_nettype wire

[src/bdr_checker.sv]
`default_nettype none

module bdr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_req_valid,
    input wire logic                            i_req_ready,
    input wire logic                            i_rsp_valid,
    input wire logic                            i_rsp_ready,
    input wire logic [bdr_pkg::STAT_W-1:0]      i_rsp_status,
    input wire logic signed [bdr_pkg::WORD_W-1:0] i_rsp_data,
    input wire logic [bdr_pkg::COUNT_W-1:0]     i_rsp_count
);
    import bdr_pkg::*;

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_data)
            && $stable(i_rsp_count))
        else $error("response changed while stalled");

    // after every accepted request a valid response is shown, its own or a stalled earlier one
    a_req_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |-> ##2 i_rsp_valid)
        else $error("response missing two cycles after request");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_FULL) |-> (i_rsp_count == COUNT_W'(DEPTH)))
        else $error("full refusal with room left");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_EMPTY) |-> (i_rsp_count == '0) && (i_rsp_data == '0))
        else $error("empty refusal with elements held");

endmodule

bind bounded_deque_with_reverse_unit bdr_checker u_bdr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_data   (o_rsp.data),
    .i_rsp_count  (o_rsp.count)
);

`default_nettype wire
